### sv/ple_pkg.sv
// shared types and constants of the positional list engine
// no dependencies; every other file of the block but ple_ram imports it
package ple_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int KIND_W   = 3;
	localparam int POS_W    = 7;
	localparam int WORD_W   = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND = 3'd0,
		KIND_INSERT = 3'd1,
		KIND_REMOVE = 3'd2,
		KIND_GET    = 3'd3,
		KIND_CLEAR  = 3'd4
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef struct packed {
		logic [WORD_W-1:0]  read_value;
		logic [COUNT_W-1:0] entry_count;
		status_t            status;
	} rsp_t;

endpackage

### sv/ple_req_if.sv
// request channel of the positional list engine: valid/ready plus request word
// depends on ple_pkg
interface ple_req_if;
	import ple_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [POS_W-1:0]  position;
	logic [WORD_W-1:0] value;

	modport source (output valid, kind, position, value, input ready);
	modport sink (input valid, kind, position, value, output ready);

endinterface

### sv/ple_rsp_if.sv
// result channel of the positional list engine: valid/ready plus result word
// depends on ple_pkg
interface ple_rsp_if;
	import ple_pkg::*;

	logic                valid;
	logic                ready;
	logic [WORD_W-1:0]   read_value;
	logic [COUNT_W-1:0]  entry_count;
	logic [STATUS_W-1:0] status;

	modport source (output valid, read_value, entry_count, status, input ready);
	modport sink (input valid, read_value, entry_count, status, output ready);

endinterface

### sv/ple_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/ple_ctrl.sv
// sequencer of the positional list engine: decodes a request, walks the list
// memory one entry per cycle for shifts and reads; uses ple_pkg, ple_req_if, ple_ram
module ple_ctrl #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ple_req_if.sink       req,
	output logic          res_valid,
	output ple_pkg::rsp_t res,
	input  logic          res_take
);
	import ple_pkg::*;

	localparam int AW    = $clog2(CAPACITY);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_PUT  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     ptr_q;
	logic [AW-1:0]     end_q;
	logic [AW-1:0]     slot_q;
	logic              dir_up_q;
	logic              rd_act_q;
	logic              first_q;
	logic              dec_q;
	logic [WORD_W-1:0] val_q;
	logic [WORD_W-1:0] rdval_q;
	status_t           status_q;

	logic              pend_s1;
	logic              cap_s1;
	logic [AW-1:0]     wr_addr_s1;

	logic              accept;
	logic              full;
	logic              pos_zero;
	logic              pos_over;
	logic [AW-1:0]     tail;
	logic [AW-1:0]     pidx;

	status_t           d_status;
	logic              d_direct_wr;
	logic              d_scan;
	logic              d_dir_up;
	logic              d_dec;
	logic              d_clear;
	logic [AW-1:0]     d_start;
	logic [AW-1:0]     d_end;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              mem_re;
	logic [WORD_W-1:0] mem_rdata;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign full     = (count_q == CW'(CAPACITY));
	assign pos_zero = (req.position == '0);
	assign pos_over = (CMP_W'(req.position) > CMP_W'(count_q));
	assign tail     = AW'(count_q);
	assign pidx     = AW'(req.position - POS_W'(1));

	always_comb begin
		d_status    = ST_OK;
		d_direct_wr = 1'b0;
		d_scan      = 1'b0;
		d_dir_up    = 1'b0;
		d_dec       = 1'b0;
		d_clear     = 1'b0;
		d_start     = pidx;
		d_end       = pidx;
		case (req.kind)
			KIND_APPEND: begin
				if (full) begin
					d_status = ST_FULL;
				end else begin
					d_direct_wr = 1'b1;
				end
			end
			KIND_INSERT: begin
				if (full) begin
					d_status = ST_FULL;
				end else if (pos_zero) begin
					d_status = ST_BAD;
				end else if (pos_over) begin
					d_direct_wr = 1'b1;
				end else begin
					// move entries tail-1 down to the slot up by one, then put the word
					d_scan   = 1'b1;
					d_dir_up = 1'b1;
					d_start  = AW'(count_q - CW'(1));
					d_end    = pidx;
				end
			end
			KIND_REMOVE: begin
				if (pos_zero || pos_over) begin
					d_status = ST_BAD;
				end else begin
					// first read returns the word, the rest slide down by one
					d_scan  = 1'b1;
					d_dec   = 1'b1;
					d_start = pidx;
					d_end   = AW'(count_q - CW'(1));
				end
			end
			KIND_GET: begin
				if (pos_zero || pos_over) begin
					d_status = ST_BAD;
				end else begin
					d_scan = 1'b1;
				end
			end
			KIND_CLEAR: begin
				d_clear = 1'b1;
			end
			default: begin
				d_status = ST_BAD;
			end
		endcase
	end

	// memory port steering
	assign mem_re = (state_q == S_SCAN) && rd_act_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tail;
		mem_wdata = req.value;
		if (accept && d_direct_wr) begin
			mem_we = 1'b1;
		end else if ((state_q == S_SCAN) && pend_s1 && !cap_s1) begin
			mem_we    = 1'b1;
			mem_waddr = wr_addr_s1;
			mem_wdata = mem_rdata;
		end else if (state_q == S_PUT) begin
			mem_we    = 1'b1;
			mem_waddr = slot_q;
			mem_wdata = val_q;
		end
	end

	ple_ram #(
		.WIDTH(WORD_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (ptr_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rd_act_q <= 1'b0;
			pend_s1  <= 1'b0;
		end else begin
			pend_s1 <= (state_q == S_SCAN) && rd_act_q;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_act_q <= d_scan;
						if (d_clear) begin
							count_q <= '0;
						end else if (d_direct_wr) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= d_scan ? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					if (rd_act_q && (ptr_q == end_q)) begin
						rd_act_q <= 1'b0;
					end
					// last read data lands this cycle
					if (!rd_act_q && pend_s1) begin
						if (dec_q) begin
							count_q <= count_q - CW'(1);
						end
						state_q <= dir_up_q ? S_PUT : S_DONE;
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdval_q  <= '0;
			status_q <= d_status;
			val_q    <= req.value;
			slot_q   <= pidx;
			ptr_q    <= d_start;
			end_q    <= d_end;
			dir_up_q <= d_dir_up;
			dec_q    <= d_dec;
			first_q  <= !d_dir_up;
		end
		if ((state_q == S_SCAN) && rd_act_q) begin
			cap_s1     <= first_q;
			first_q    <= 1'b0;
			wr_addr_s1 <= dir_up_q ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));
			if (ptr_q != end_q) begin
				ptr_q <= dir_up_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
			end
		end
		if ((state_q == S_SCAN) && pend_s1 && cap_s1) begin
			rdval_q <= mem_rdata;
		end
	end

	assign res_valid       = (state_q == S_DONE);
	assign res.read_value  = rdval_q;
	assign res.entry_count = COUNT_W'(count_q);
	assign res.status      = status_q;

endmodule

### sv/positional_list_engine_unit.sv
// Positional list engine: an ordered list of up to CAPACITY 32-bit words held in one
// synchronous memory, addressed by 1-based position, with append, insert, remove, get
// and clear requests and exactly one result word per request. One request is worked at
// a time and the memory port sets the pace: append, clear and every error skip the
// memory walk, get reads one entry, and insert or remove walk every entry behind the
// position. A result waits in an output register, so the next request is taken while
// it is still unread.
// depends on ple_pkg, ple_req_if, ple_rsp_if, ple_ctrl
module positional_list_engine_unit #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ple_req_if.sink   req,
	ple_rsp_if.source rsp
);
	import ple_pkg::*;

	logic res_valid;
	rsp_t res;
	logic res_take;
	logic out_valid_q;
	rsp_t out_q;

	ple_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	// output word register, refilled as it drains
	assign res_take = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_value  = out_q.read_value;
	assign rsp.entry_count = out_q.entry_count;
	assign rsp.status      = out_q.status;

endmodule
